// ===== hdl/pfde_pkg.sv =====
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared constants, types and the 6x8 font for the page framebuffer engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

   localparam int unsigned COLUMNS_DEF = 128;
   localparam int unsigned ROWS_DEF    = 64;

   localparam int unsigned KIND_W     = 3;
   localparam int unsigned COORD_W    = 8;
   localparam int unsigned DATA_W     = 8;
   localparam int unsigned PAGE_H     = 8;
   localparam int unsigned PAGE_IDX_W = COORD_W - $clog2(PAGE_H);
   localparam int unsigned BLIT_PG_W  = 6;

   localparam int unsigned GLYPH_COLS  = 6;
   localparam int unsigned GLYPH_FIRST = 32;
   localparam int unsigned GLYPH_LAST  = 126;
   localparam int unsigned GLYPH_COUNT = GLYPH_LAST - GLYPH_FIRST + 1;
   localparam int unsigned GLYPH_IDX_W = $clog2(GLYPH_COUNT);
   localparam int unsigned GLYPH_COL_W = $clog2(GLYPH_COLS);

   typedef enum logic [KIND_W-1:0] {
      KIND_PIXEL      = 3'd0,
      KIND_BLIT_START = 3'd1,
      KIND_BLIT_BYTE  = 3'd2,
      KIND_GLYPH      = 3'd3,
      KIND_CLEAR      = 3'd4,
      KIND_READ       = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_DRAW  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ  = 2'd3
   } cmd_op_type;

   // one column access: row y is the top of the 8 rows, half picks the lower page
   typedef struct packed {
      cmd_op_type          op;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic                half;
      logic [DATA_W-1:0]   mask;
      logic [DATA_W-1:0]   bits;
   } col_cmd_type;

   // columns 0..5 from left to right, bit 0 of each column is the top row
   localparam logic [47:0] GLYPH_ROM [GLYPH_COUNT] = '{
      48'h000000000000, 48'h00005F000000, 48'h000700070000, 48'h147F147F1400,
      48'h242A7F2A1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
      48'h001C22410000, 48'h0041221C0000, 48'h14083E081400, 48'h08083E080800,
      48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
      48'h3E5149453E00, 48'h00427F400000, 48'h426151494600, 48'h2141454B3100,
      48'h1814127F1000, 48'h274545453900, 48'h3C4A49493000, 48'h017109050300,
      48'h364949493600, 48'h064949291E00, 48'h003636000000, 48'h005636000000,
      48'h081422410000, 48'h141414141400, 48'h412214080000, 48'h020151090600,
      48'h324979413E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
      48'h7F4141221C00, 48'h7F4949494100, 48'h7F0909010100, 48'h3E4141513200,
      48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
      48'h7F4040404000, 48'h7F0204027F00, 48'h7F0408107F00, 48'h3E4141413E00,
      48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h464949493100,
      48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h7F2018207F00,
      48'h631408146300, 48'h030478040300, 48'h615149454300, 48'h007F41410000,
      48'h020408102000, 48'h0041417F0000, 48'h040201020400, 48'h404040404000,
      48'h000102040000, 48'h205454547800, 48'h7F4844443800, 48'h384444442000,
      48'h384444487F00, 48'h385454541800, 48'h087E09010200, 48'h0C5252523E00,
      48'h7F0804047800, 48'h00447D400000, 48'h2040443D0000, 48'h7F1028440000,
      48'h00417F400000, 48'h7C0478047800, 48'h7C0804047800, 48'h384444443800,
      48'h7C1414140800, 48'h081414187C00, 48'h7C0804040800, 48'h485454542000,
      48'h043F44402000, 48'h3C4040207C00, 48'h1C2040201C00, 48'h3C4030403C00,
      48'h442810284400, 48'h0C5050503C00, 48'h4464544C4400, 48'h000836410000,
      48'h00007F000000, 48'h004136080000, 48'h08082A1C0800
   };

   function automatic logic [DATA_W-1:0] glyph_column(
      input logic [GLYPH_IDX_W-1:0] code,
      input logic [GLYPH_COL_W-1:0] col
   );
      logic [47:0] row;
      row = GLYPH_ROM[code];
      case (col)
         3'd0:    glyph_column = row[47:40];
         3'd1:    glyph_column = row[39:32];
         3'd2:    glyph_column = row[31:24];
         3'd3:    glyph_column = row[23:16];
         3'd4:    glyph_column = row[15:8];
         3'd5:    glyph_column = row[7:0];
         default: glyph_column = '0;
      endcase
   endfunction

endpackage

// ===== hdl/pfde_if.sv =====
// ----------------------------------------------------------------------------
// pfde_if
// Valid/ready channels of the page framebuffer engine: draw requests and
// read responses.
// ----------------------------------------------------------------------------
interface pfde_req_if;
   logic                               valid;
   logic                               ready;
   logic [pfde_pkg::KIND_W-1:0]        kind;
   logic [pfde_pkg::COORD_W-1:0]       pos_x;
   logic [pfde_pkg::COORD_W-1:0]       pos_y;
   logic [pfde_pkg::COORD_W-1:0]       blit_w;
   logic [pfde_pkg::COORD_W-1:0]       blit_h;
   logic [pfde_pkg::DATA_W-1:0]        value;
   logic                               mode;

   modport source (
      output valid, kind, pos_x, pos_y, blit_w, blit_h, value, mode,
      input  ready
   );
   modport sink (
      input  valid, kind, pos_x, pos_y, blit_w, blit_h, value, mode,
      output ready
   );
endinterface

interface pfde_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [pfde_pkg::DATA_W-1:0]        read_data;

   modport source (
      output valid, read_data,
      input  ready
   );
   modport sink (
      input  valid, read_data,
      output ready
   );
endinterface

// ===== hdl/pfde_ram.sv =====
// ----------------------------------------------------------------------------
// pfde_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module pfde_ram #(
   parameter int unsigned WIDTH = pfde_pkg::DATA_W,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pfde_rmw.sv =====
// ----------------------------------------------------------------------------
// pfde_rmw
// Column access unit: maps a column command onto a page byte, clips it,
// reads the byte and merges the new bits in on the following cycle.
// ----------------------------------------------------------------------------
module pfde_rmw #(
   parameter int unsigned COLUMNS = pfde_pkg::COLUMNS_DEF,
   parameter int unsigned ROWS    = pfde_pkg::ROWS_DEF,
   localparam int unsigned PAGE_COUNT = (ROWS + pfde_pkg::PAGE_H - 1) / pfde_pkg::PAGE_H,
   localparam int unsigned COL_W      = $clog2(COLUMNS),
   localparam int unsigned DEPTH      = PAGE_COUNT << COL_W,
   localparam int unsigned AW         = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pfde_pkg::col_cmd_type         cmd,
   input  logic [pfde_pkg::DATA_W-1:0]   ram_rd_data,
   output logic                          ram_wr_en,
   output logic [AW-1:0]                 ram_wr_addr,
   output logic [pfde_pkg::DATA_W-1:0]   ram_wr_data,
   output logic                          ram_rd_en,
   output logic [AW-1:0]                 ram_rd_addr
);

   localparam int unsigned DW  = pfde_pkg::DATA_W;
   localparam int unsigned PGW = pfde_pkg::PAGE_IDX_W;

   logic [PGW-1:0]  page_k;
   logic [2*DW-1:0] mask_wide;
   logic [2*DW-1:0] bits_wide;
   logic [DW-1:0]   mask_k;
   logic [DW-1:0]   bits_k;
   logic [DW-1:0]   row_ok;
   logic [DW-1:0]   mask_eff;
   logic            col_ok;
   logic            draw_en;
   logic            clear_now;
   logic [AW-1:0]   addr;

   logic            wr_pend_ff, wr_pend_in;
   logic [AW-1:0]   wr_addr_ff;
   logic [DW-1:0]   wr_mask_ff;
   logic [DW-1:0]   wr_bits_ff;

   always_comb begin
      page_k    = cmd.y[pfde_pkg::COORD_W-1 -: PGW] + PGW'(cmd.half);
      mask_wide = {{DW{1'b0}}, cmd.mask} << cmd.y[2:0];
      bits_wide = {{DW{1'b0}}, cmd.bits} << cmd.y[2:0];
      // the lower page gets what spills over the bottom of the upper one
      mask_k    = cmd.half ? mask_wide[2*DW-1:DW] : mask_wide[DW-1:0];
      bits_k    = cmd.half ? bits_wide[2*DW-1:DW] : bits_wide[DW-1:0];
      for (int b = 0; b < DW; b++) begin
         row_ok[b] = ({1'b0, page_k, 3'(b)} < 9'(ROWS));
      end
      col_ok    = ({1'b0, cmd.x} < 9'(COLUMNS));
      mask_eff  = col_ok ? (mask_k & row_ok) : '0;
      draw_en   = (cmd.op == pfde_pkg::CMD_DRAW) && (mask_eff != '0);
      clear_now = (cmd.op == pfde_pkg::CMD_CLEAR);
      addr      = AW'({page_k, cmd.x[COL_W-1:0]});
   end

   assign wr_pend_in  = draw_en;
   assign ram_rd_en   = draw_en || (cmd.op == pfde_pkg::CMD_READ);
   assign ram_rd_addr = addr;
   assign ram_wr_en   = clear_now || wr_pend_ff;
   assign ram_wr_addr = clear_now ? addr : wr_addr_ff;
   assign ram_wr_data = clear_now ? '0
                                  : ((ram_rd_data & ~wr_mask_ff) | (wr_bits_ff & wr_mask_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= wr_pend_in;
      end
      wr_addr_ff <= addr;
      wr_mask_ff <= mask_eff;
      wr_bits_ff <= bits_k;
   end

endmodule

// ===== hdl/pfde_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfde_ctrl
// Item sequencer: decodes draw requests, keeps the blit cursor, steps through
// the column accesses of each item, runs the clearing sweep and holds the
// read response.
// ----------------------------------------------------------------------------
module pfde_ctrl #(
   parameter int unsigned COLUMNS = pfde_pkg::COLUMNS_DEF,
   parameter int unsigned ROWS    = pfde_pkg::ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   pfde_req_if.sink                      req_chan,
   pfde_rsp_if.source                    rsp_chan,
   input  logic [pfde_pkg::DATA_W-1:0]   ram_rd_data,
   output pfde_pkg::col_cmd_type         cmd
);

   localparam int unsigned PAGE_COUNT = (ROWS + pfde_pkg::PAGE_H - 1) / pfde_pkg::PAGE_H;
   localparam int unsigned COL_W      = $clog2(COLUMNS);
   localparam int unsigned PG_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
   localparam logic [PG_W-1:0]  PG_LAST  = PG_W'(PAGE_COUNT - 1);
   localparam int unsigned CW  = pfde_pkg::COORD_W;
   localparam int unsigned DW  = pfde_pkg::DATA_W;
   localparam int unsigned BPW = pfde_pkg::BLIT_PG_W;
   localparam int unsigned GIW = pfde_pkg::GLYPH_IDX_W;
   localparam int unsigned GCW = pfde_pkg::GLYPH_COL_W;
   localparam logic [GCW-1:0] GLYPH_COL_LAST = GCW'(pfde_pkg::GLYPH_COLS - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CLEAR = 5'b00010,
      ST_DRAW  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic             accept;

   // item being drawn
   logic [CW-1:0]    op_x_ff, op_x_in;
   logic [CW-1:0]    op_y_ff, op_y_in;
   logic [DW-1:0]    op_mask_ff, op_mask_in;
   logic [DW-1:0]    op_bits_ff, op_bits_in;
   logic             op_glyph_ff, op_glyph_in;
   logic [GIW-1:0]   op_code_ff, op_code_in;
   logic [GCW-1:0]   op_last_ff, op_last_in;
   logic [GCW-1:0]   slot_col_ff, slot_col_in;
   logic             slot_half_ff, slot_half_in;

   // clearing sweep
   logic [COL_W-1:0] clr_x_ff, clr_x_in;
   logic [PG_W-1:0]  clr_pg_ff, clr_pg_in;

   // blit cursor
   logic [CW-1:0]    blit_x_ff, blit_x_in;
   logic [CW-1:0]    blit_y_ff, blit_y_in;
   logic [CW-1:0]    blit_w_ff, blit_w_in;
   logic [BPW-1:0]   blit_pages_ff, blit_pages_in;
   logic [CW-1:0]    blit_col_ff, blit_col_in;
   logic [BPW-1:0]   blit_page_ff, blit_page_in;
   logic             blit_pol_ff, blit_pol_in;
   logic             blit_active;
   logic [CW-1:0]    blit_col_inc;

   // read response
   logic             rd_ok_ff, rd_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]    rsp_data_ff, rsp_data_in;
   logic             rd_in_range;

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign accept             = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;

   assign blit_active  = (blit_w_ff != '0) && (blit_page_ff < blit_pages_ff);
   assign blit_col_inc = blit_col_ff + CW'(1);
   assign rd_in_range  = ({1'b0, req_chan.pos_x} < 9'(COLUMNS))
                         && ({1'b0, req_chan.pos_y} < 9'(PAGE_COUNT));

   always_comb begin
      state_in      = state_ff;
      op_x_in       = op_x_ff;
      op_y_in       = op_y_ff;
      op_mask_in    = op_mask_ff;
      op_bits_in    = op_bits_ff;
      op_glyph_in   = op_glyph_ff;
      op_code_in    = op_code_ff;
      op_last_in    = op_last_ff;
      slot_col_in   = slot_col_ff;
      slot_half_in  = slot_half_ff;
      clr_x_in      = clr_x_ff;
      clr_pg_in     = clr_pg_ff;
      blit_x_in     = blit_x_ff;
      blit_y_in     = blit_y_ff;
      blit_w_in     = blit_w_ff;
      blit_pages_in = blit_pages_ff;
      blit_col_in   = blit_col_ff;
      blit_page_in  = blit_page_ff;
      blit_pol_in   = blit_pol_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      cmd           = '0;
      cmd.op        = pfde_pkg::CMD_NONE;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               slot_col_in  = '0;
               slot_half_in = 1'b0;
               op_x_in      = req_chan.pos_x;
               op_y_in      = req_chan.pos_y;
               op_bits_in   = {DW{req_chan.mode}};
               op_mask_in   = DW'(1);
               op_glyph_in  = 1'b0;
               op_last_in   = '0;
               case (pfde_pkg::kind_type'(req_chan.kind))
                  pfde_pkg::KIND_PIXEL: begin
                     state_in = ST_DRAW;
                  end
                  pfde_pkg::KIND_BLIT_START: begin
                     blit_x_in     = req_chan.pos_x;
                     blit_y_in     = req_chan.pos_y;
                     blit_w_in     = req_chan.blit_w;
                     blit_pages_in = BPW'(req_chan.blit_h >> 3) + BPW'(|req_chan.blit_h[2:0]);
                     blit_col_in   = '0;
                     blit_page_in  = '0;
                     blit_pol_in   = req_chan.mode;
                  end
                  pfde_pkg::KIND_BLIT_BYTE: begin
                     if (blit_active) begin
                        op_x_in    = blit_x_ff + blit_col_ff;
                        op_y_in    = blit_y_ff + {blit_page_ff[4:0], 3'b000};
                        op_mask_in = '1;
                        // 1 bits take the polarity, 0 bits its inverse
                        op_bits_in = ~(req_chan.value ^ {DW{blit_pol_ff}});
                        state_in   = ST_DRAW;
                        if (blit_col_inc >= blit_w_ff) begin
                           blit_col_in  = '0;
                           blit_page_in = blit_page_ff + BPW'(1);
                        end else begin
                           blit_col_in  = blit_col_inc;
                        end
                     end
                  end
                  pfde_pkg::KIND_GLYPH: begin
                     op_glyph_in = 1'b1;
                     op_last_in  = GLYPH_COL_LAST;
                     if ((req_chan.value < DW'(pfde_pkg::GLYPH_FIRST))
                         || (req_chan.value > DW'(pfde_pkg::GLYPH_LAST))) begin
                        op_code_in = '0;
                     end else begin
                        op_code_in = GIW'(req_chan.value - DW'(pfde_pkg::GLYPH_FIRST));
                     end
                     state_in = ST_DRAW;
                  end
                  pfde_pkg::KIND_CLEAR: begin
                     clr_x_in  = '0;
                     clr_pg_in = '0;
                     state_in  = ST_CLEAR;
                  end
                  pfde_pkg::KIND_READ: begin
                     rd_ok_in = rd_in_range;
                     if (rd_in_range) begin
                        cmd.op = pfde_pkg::CMD_READ;
                        cmd.x  = req_chan.pos_x;
                        cmd.y  = {req_chan.pos_y[4:0], 3'b000};
                     end
                     state_in = ST_RESP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.op = pfde_pkg::CMD_CLEAR;
            cmd.x  = CW'(clr_x_ff);
            cmd.y  = CW'(clr_pg_ff) << 3;
            if (clr_x_ff == COL_LAST) begin
               clr_x_in  = '0;
               clr_pg_in = clr_pg_ff + PG_W'(1);
               if (clr_pg_ff == PG_LAST) begin
                  state_in = ST_IDLE;
               end
            end else begin
               clr_x_in = clr_x_ff + COL_W'(1);
            end
         end
         ST_DRAW: begin
            cmd.op   = pfde_pkg::CMD_DRAW;
            cmd.x    = op_x_ff + CW'(slot_col_ff);
            cmd.y    = op_y_ff;
            cmd.half = slot_half_ff;
            cmd.mask = op_glyph_ff ? pfde_pkg::glyph_column(op_code_ff, slot_col_ff)
                                   : op_mask_ff;
            cmd.bits = op_bits_ff;
            slot_half_in = !slot_half_ff;
            if (slot_half_ff) begin
               slot_col_in = slot_col_ff + GCW'(1);
               if (slot_col_ff == op_last_ff) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_ok_ff ? ram_rd_data : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_x_ff      <= '0;
         clr_pg_ff     <= '0;
         slot_col_ff   <= '0;
         slot_half_ff  <= 1'b0;
         blit_x_ff     <= '0;
         blit_y_ff     <= '0;
         blit_w_ff     <= '0;
         blit_pages_ff <= '0;
         blit_col_ff   <= '0;
         blit_page_ff  <= '0;
         blit_pol_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_x_ff      <= clr_x_in;
         clr_pg_ff     <= clr_pg_in;
         slot_col_ff   <= slot_col_in;
         slot_half_ff  <= slot_half_in;
         blit_x_ff     <= blit_x_in;
         blit_y_ff     <= blit_y_in;
         blit_w_ff     <= blit_w_in;
         blit_pages_ff <= blit_pages_in;
         blit_col_ff   <= blit_col_in;
         blit_page_ff  <= blit_page_in;
         blit_pol_ff   <= blit_pol_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_x_ff     <= op_x_in;
      op_y_ff     <= op_y_in;
      op_mask_ff  <= op_mask_in;
      op_bits_ff  <= op_bits_in;
      op_glyph_ff <= op_glyph_in;
      op_code_ff  <= op_code_in;
      op_last_ff  <= op_last_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hdl/page_framebuffer_draw_engine.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Monochrome framebuffer in vertical 8-pixel pages with pixel, blit, glyph,
// clear and read-back items.
// ----------------------------------------------------------------------------
// Items arrive on req_chan (valid/ready) and one at a time are worked on.
// Only a read item gives a response item on rsp_chan, carrying one page byte
// (bit 0 the top row); reads outside the screen return zero.
// Work per item after the accept: none for a blit start or an ignored
// kind; a read registers its response; a pixel or blit column byte reads
// and writes back up to two pages; a glyph does so for 6 columns, two
// pages each; a clear sweeps all COLUMNS * page count bytes.
// The single RAM takes one read and one write per cycle, with registered
// read data, so each page byte is a read and a write-back.
// After reset the whole RAM is swept to zero, COLUMNS * page count bytes
// (1024 at 128x64), with req_chan.ready low; the blit cursor is cleared.
// A response waits in its output register while rsp_chan.ready is low; the
// next item is still taken, and only a following read holds in its last
// cycle until the register frees.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine #(
   parameter int unsigned COLUMNS = pfde_pkg::COLUMNS_DEF,
   parameter int unsigned ROWS    = pfde_pkg::ROWS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pfde_req_if.sink     req_chan,
   pfde_rsp_if.source   rsp_chan
);

   localparam int unsigned PAGE_COUNT = (ROWS + pfde_pkg::PAGE_H - 1) / pfde_pkg::PAGE_H;
   localparam int unsigned COL_W      = $clog2(COLUMNS);
   localparam int unsigned DEPTH      = PAGE_COUNT << COL_W;
   localparam int unsigned AW         = $clog2(DEPTH);

   pfde_pkg::col_cmd_type          cmd;
   logic                           ram_wr_en;
   logic [AW-1:0]                  ram_wr_addr;
   logic [pfde_pkg::DATA_W-1:0]    ram_wr_data;
   logic                           ram_rd_en;
   logic [AW-1:0]                  ram_rd_addr;
   logic [pfde_pkg::DATA_W-1:0]    ram_rd_data;

   pfde_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .ram_rd_data (ram_rd_data),
      .cmd         (cmd)
   );

   pfde_rmw #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_rmw (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr)
   );

   pfde_ram #(
      .WIDTH (pfde_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== hdl/pfde_checker.sv =====
// ----------------------------------------------------------------------------
// pfde_checker
// Port-level checks on the page framebuffer engine, bound to the top level.
// ----------------------------------------------------------------------------
module pfde_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [pfde_pkg::KIND_W-1:0]   req_kind,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pfde_pkg::DATA_W-1:0]   rsp_read_data
);

   logic read_accept;
   logic clear_accept;

   assign read_accept  = req_valid && req_ready && (req_kind == pfde_pkg::KIND_READ);
   assign clear_accept = req_valid && req_ready && (req_kind == pfde_pkg::KIND_CLEAR);

   // the clearing sweep follows reset, so no item is taken straight away
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("item taken during the reset clearing sweep");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled response item dropped or changed");

   // a fresh response only ever rises from the response state entered by a read item
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(read_accept, 2))
      else $error("response item without a read item");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      read_accept |=> !req_ready)
      else $error("item taken while a read is in flight");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      clear_accept |=> !req_ready)
      else $error("item taken while clearing");

endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_kind      (req_chan.kind),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_read_data (rsp_chan.read_data)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page framebuffer draw engine. A shadow copy of
// the framebuffer and blit cursor is updated on every accepted item; each
// read-back response is checked against the page byte that the shadow holds.
// Stimulus is a directed opening followed by random pixel, glyph, blit,
// clear, read and spare-kind traffic, bursty requests and stalled responses.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned COLUMNS  = pfde_pkg::COLUMNS_DEF;
   localparam int unsigned ROWS     = pfde_pkg::ROWS_DEF;
   localparam int unsigned PAGES    = (ROWS + 7) / 8;
   localparam int unsigned ITEM_CNT = 1350;
   localparam int unsigned KW       = pfde_pkg::KIND_W;
   localparam int unsigned CW       = pfde_pkg::COORD_W;
   localparam int unsigned DW       = pfde_pkg::DATA_W;
   localparam int unsigned BPW      = pfde_pkg::BLIT_PG_W;

   // kinds that the engine drops without a response
   localparam logic [KW-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KW-1:0] KIND_SPARE_B = 3'd7;

   // columns 0..5 from bits 47:40 down, bit 0 of each column is the top row
   localparam logic [47:0] FONT_6X8 [95] = '{
      48'h000000000000, 48'h00005F000000, 48'h000700070000, 48'h147F147F1400,
      48'h242A7F2A1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
      48'h001C22410000, 48'h0041221C0000, 48'h14083E081400, 48'h08083E080800,
      48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
      48'h3E5149453E00, 48'h00427F400000, 48'h426151494600, 48'h2141454B3100,
      48'h1814127F1000, 48'h274545453900, 48'h3C4A49493000, 48'h017109050300,
      48'h364949493600, 48'h064949291E00, 48'h003636000000, 48'h005636000000,
      48'h081422410000, 48'h141414141400, 48'h412214080000, 48'h020151090600,
      48'h324979413E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
      48'h7F4141221C00, 48'h7F4949494100, 48'h7F0909010100, 48'h3E4141513200,
      48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
      48'h7F4040404000, 48'h7F0204027F00, 48'h7F0408107F00, 48'h3E4141413E00,
      48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h464949493100,
      48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h7F2018207F00,
      48'h631408146300, 48'h030478040300, 48'h615149454300, 48'h007F41410000,
      48'h020408102000, 48'h0041417F0000, 48'h040201020400, 48'h404040404000,
      48'h000102040000, 48'h205454547800, 48'h7F4844443800, 48'h384444442000,
      48'h384444487F00, 48'h385454541800, 48'h087E09010200, 48'h0C5252523E00,
      48'h7F0804047800, 48'h00447D400000, 48'h2040443D0000, 48'h7F1028440000,
      48'h00417F400000, 48'h7C0478047800, 48'h7C0804047800, 48'h384444443800,
      48'h7C1414140800, 48'h081414187C00, 48'h7C0804040800, 48'h485454542000,
      48'h043F44402000, 48'h3C4040207C00, 48'h1C2040201C00, 48'h3C4030403C00,
      48'h442810284400, 48'h0C5050503C00, 48'h4464544C4400, 48'h000836410000,
      48'h00007F000000, 48'h004136080000, 48'h08082A1C0800
   };

   typedef struct packed {
      logic [KW-1:0]  kind;
      logic [CW-1:0]  pos_x;
      logic [CW-1:0]  pos_y;
      logic [CW-1:0]  blit_w;
      logic [CW-1:0]  blit_h;
      logic [DW-1:0]  value;
      logic           mode;
   } draw_item_type;

   logic clock;
   logic reset;

   pfde_req_if req_chan ();
   pfde_rsp_if rsp_chan ();

   page_framebuffer_draw_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow framebuffer and blit cursor
   logic [DW-1:0]    shadow_fb [COLUMNS*PAGES];
   logic [CW-1:0]    blit_ox;
   logic [CW-1:0]    blit_oy;
   logic [CW-1:0]    blit_cols;
   logic [BPW-1:0]   blit_npages;
   logic [CW-1:0]    blit_col;
   logic [BPW-1:0]   blit_pg;
   logic             blit_pol;

   draw_item_type     draw_items_q [$];
   logic [DW-1:0]     read_bytes_due [$];
   draw_item_type     in_flight;
   int                total_items;
   int                accepted;
   int                fail_count;
   int                burst_left;
   int                gap_left;
   logic [9:0]        stall_tick;

   initial begin
      clock = 1'b0;
   end
   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // shadow model
   // ------------------------------------------------------------------
   task automatic plot(input logic [7:0] x, input logic [7:0] y, input logic on);
      int idx;
      if (x < COLUMNS && y < ROWS) begin
         idx = int'(x) + int'(y >> 3) * COLUMNS;
         shadow_fb[idx][y[2:0]] = on;
      end
   endtask

   task automatic apply_item(input draw_item_type it);
      logic [7:0]  cx;
      logic [7:0]  cy;
      logic [7:0]  code;
      logic [47:0] glyph;
      logic [7:0]  gcol;
      logic [7:0]  rd;
      case (it.kind)
         pfde_pkg::KIND_PIXEL: begin
            plot(it.pos_x, it.pos_y, it.mode);
         end
         pfde_pkg::KIND_BLIT_START: begin
            blit_ox     = it.pos_x;
            blit_oy     = it.pos_y;
            blit_cols   = it.blit_w;
            blit_npages = BPW'((it.blit_h >> 3) + ((it.blit_h[2:0] != 3'd0) ? 1 : 0));
            blit_col    = '0;
            blit_pg     = '0;
            blit_pol    = it.mode;
         end
         pfde_pkg::KIND_BLIT_BYTE: begin
            if (blit_cols != 0 && blit_pg < blit_npages) begin
               cx = blit_ox + blit_col;
               cy = blit_oy + 8'(blit_pg * 8);
               for (int j = 0; j < 8; j++)
                  plot(cx, cy + 8'(j), it.value[j] ? blit_pol : ~blit_pol);
               blit_col = blit_col + 1'b1;
               if (blit_col >= blit_cols) begin
                  blit_col = '0;
                  blit_pg  = blit_pg + 1'b1;
               end
            end
         end
         pfde_pkg::KIND_GLYPH: begin
            code = it.value;
            if (code < pfde_pkg::GLYPH_FIRST || code > pfde_pkg::GLYPH_LAST)
               code = 8'(pfde_pkg::GLYPH_FIRST);
            glyph = FONT_6X8[code - pfde_pkg::GLYPH_FIRST];
            for (int i = 0; i < 6; i++) begin
               gcol = glyph[47 - 8*i -: 8];
               for (int j = 0; j < 8; j++)
                  if (gcol[j])
                     plot(it.pos_x + 8'(i), it.pos_y + 8'(j), it.mode);
            end
         end
         pfde_pkg::KIND_CLEAR: begin
            foreach (shadow_fb[k]) shadow_fb[k] = '0;
         end
         pfde_pkg::KIND_READ: begin
            rd = '0;
            if (it.pos_x < COLUMNS && it.pos_y < PAGES)
               rd = shadow_fb[int'(it.pos_x) + int'(it.pos_y) * COLUMNS];
            read_bytes_due.push_back(rd);
         end
         default: begin
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic draw_item_type rand_item(input logic [KW-1:0] kind);
      draw_item_type it;
      it.kind   = kind;
      it.pos_x  = 8'($urandom_range(0, 255));
      it.pos_y  = 8'($urandom_range(0, 255));
      it.blit_w = 8'($urandom_range(0, 255));
      it.blit_h = 8'($urandom_range(0, 255));
      it.value  = 8'($urandom_range(0, 255));
      it.mode   = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic draw_item_type make_item(input logic [KW-1:0] kind,
                                               input logic [7:0] x, input logic [7:0] y,
                                               input logic [7:0] w, input logic [7:0] h,
                                               input logic [7:0] v, input logic m);
      draw_item_type it;
      it = '{kind, x, y, w, h, v, m};
      return it;
   endfunction

   function automatic logic [7:0] rand_col();
      return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, COLUMNS - 1))
                                        : 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] rand_row();
      return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, ROWS - 1))
                                        : 8'($urandom_range(0, 255));
   endfunction

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      draw_item_type it;
      logic [7:0] focus_x;
      logic [7:0] focus_y;
      int         counted;
      int         sel;
      int         w;
      int         h;
      int         npg;
      int         nbytes;

      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.kind      = '0;
      req_chan.pos_x     = '0;
      req_chan.pos_y     = '0;
      req_chan.blit_w    = '0;
      req_chan.blit_h    = '0;
      req_chan.value     = '0;
      req_chan.mode      = 1'b0;
      rsp_chan.ready     = 1'b0;
      fail_count         = 0;
      accepted           = 0;
      burst_left         = 0;
      gap_left           = 0;
      stall_tick         = '0;
      foreach (shadow_fb[k]) shadow_fb[k] = '0;
      blit_ox = '0; blit_oy = '0; blit_cols = '0; blit_npages = '0;
      blit_col = '0; blit_pg = '0; blit_pol = 1'b0;

      // directed opening
      draw_items_q.push_back(make_item(pfde_pkg::KIND_BLIT_BYTE, 0, 0, 0, 0, 8'hFF, 1));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_READ, 0, 0, 0, 0, 0, 0));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_PIXEL, 0, 0, 0, 0, 0, 1));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_PIXEL, 127, 63, 0, 0, 0, 1));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_PIXEL, 255, 255, 255, 255, 255, 1));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_READ, 0, 0, 0, 0, 0, 0));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_READ, 127, 7, 0, 0, 0, 0));
      // glyph straddling the right-hand wrap point
      draw_items_q.push_back(make_item(pfde_pkg::KIND_GLYPH, 254, 0, 0, 0, 8'h41, 1));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_GLYPH, 30, 8, 0, 0, 8'hFF, 1));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_GLYPH, 124, 60, 0, 0, 8'd126, 1));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_PIXEL, 1, 1, 0, 0, 0, 0));
      // zero width and zero height blits leave nothing running
      draw_items_q.push_back(make_item(pfde_pkg::KIND_BLIT_START, 40, 8, 0, 8, 0, 1));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_BLIT_BYTE, 0, 0, 0, 0, 8'hFF, 0));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_BLIT_START, 40, 8, 4, 0, 0, 1));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_BLIT_BYTE, 0, 0, 0, 0, 8'hFF, 0));
      // widest blit, abandoned by the next start
      draw_items_q.push_back(make_item(pfde_pkg::KIND_BLIT_START, 100, 250, 255, 255, 0, 0));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_BLIT_BYTE, 0, 0, 0, 0, 8'h00, 0));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_BLIT_START, 10, 3, 2, 9, 0, 1));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_BLIT_BYTE, 0, 0, 0, 0, 8'hA5, 0));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_BLIT_BYTE, 0, 0, 0, 0, 8'h5A, 0));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_BLIT_BYTE, 0, 0, 0, 0, 8'hFF, 0));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_BLIT_BYTE, 0, 0, 0, 0, 8'h00, 0));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_BLIT_BYTE, 0, 0, 0, 0, 8'h33, 0));
      draw_items_q.push_back(make_item(KIND_SPARE_A, 0, 0, 0, 0, 0, 0));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_READ, 11, 0, 0, 0, 0, 0));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_READ, 10, 1, 0, 0, 0, 0));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_READ, 200, 0, 0, 0, 0, 0));
      draw_items_q.push_back(make_item(pfde_pkg::KIND_READ, 0, 8, 0, 0, 0, 0));

      // random part
      focus_x = '0;
      focus_y = '0;
      counted = 0;
      while (counted < ITEM_CNT) begin
         sel = $urandom_range(0, 99);
         if (sel < 18) begin
            it = rand_item(pfde_pkg::KIND_PIXEL);
            it.pos_x = rand_col();
            it.pos_y = rand_row();
            focus_x = it.pos_x; focus_y = it.pos_y;
            draw_items_q.push_back(it);
            counted++;
         end else if (sel < 33) begin
            it = rand_item(pfde_pkg::KIND_GLYPH);
            it.pos_x = rand_col();
            it.pos_y = rand_row();
            if ($urandom_range(0, 9) < 8)
               it.value = 8'($urandom_range(pfde_pkg::GLYPH_FIRST, pfde_pkg::GLYPH_LAST));
            focus_x = it.pos_x; focus_y = it.pos_y;
            draw_items_q.push_back(it);
            counted++;
         end else if (sel < 58) begin
            // blit sequence, mostly complete, now and then cut short, often overrun
            w = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 24);
            npg = (h + 7) / 8;
            it = rand_item(pfde_pkg::KIND_BLIT_START);
            it.pos_x  = rand_col();
            it.pos_y  = rand_row();
            it.blit_w = 8'(w);
            it.blit_h = 8'(h);
            focus_x = it.pos_x; focus_y = it.pos_y;
            draw_items_q.push_back(it);
            counted++;
            nbytes = w * npg;
            if ($urandom_range(0, 9) == 0)
               nbytes = $urandom_range(0, nbytes);
            for (int b = 0; b < nbytes; b++) begin
               draw_items_q.push_back(rand_item(pfde_pkg::KIND_BLIT_BYTE));
               counted++;
            end
            repeat ($urandom_range(0, 2)) begin
               draw_items_q.push_back(rand_item(pfde_pkg::KIND_BLIT_BYTE));
               counted++;
            end
         end else if (sel < 60) begin
            draw_items_q.push_back(rand_item(pfde_pkg::KIND_CLEAR));
            counted++;
         end else if (sel < 62) begin
            draw_items_q.push_back(rand_item($urandom_range(0, 1) ? KIND_SPARE_A
                                                                  : KIND_SPARE_B));
            counted++;
         end else if (sel < 64) begin
            draw_items_q.push_back(rand_item(pfde_pkg::KIND_BLIT_BYTE));
            counted++;
         end else begin
            repeat ($urandom_range(1, 3)) begin
               it = rand_item(pfde_pkg::KIND_READ);
               if ($urandom_range(0, 6) != 0) begin
                  it.pos_x = focus_x + 8'($urandom_range(0, 9));
                  it.pos_y = (focus_y >> 3) + 8'($urandom_range(0, 3));
               end else if ($urandom_range(0, 1) == 0) begin
                  it.pos_y = 8'($urandom_range(0, PAGES + 1));
               end
               draw_items_q.push_back(it);
               counted++;
            end
         end
      end
      total_items = draw_items_q.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (accepted == total_items);
      wait (read_bytes_due.size() == 0);
      // a trailing clear may still be sweeping the store
      repeat (1200) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // request driver: bursts with random gaps
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            apply_item(in_flight);
            accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (draw_items_q.size() != 0) begin
               in_flight       = draw_items_q.pop_front();
               req_chan.kind   <= in_flight.kind;
               req_chan.pos_x  <= in_flight.pos_x;
               req_chan.pos_y  <= in_flight.pos_y;
               req_chan.blit_w <= in_flight.blit_w;
               req_chan.blit_h <= in_flight.blit_h;
               req_chan.value  <= in_flight.value;
               req_chan.mode   <= in_flight.mode;
               req_chan.valid  <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // response monitor and stall pattern
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      logic [DW-1:0] want;
      stall_tick <= stall_tick + 1'b1;
      case (stall_tick[9:8])
         2'd0:    rsp_chan.ready <= 1'b1;
         2'd1:    rsp_chan.ready <= ($urandom_range(0, 2) != 0);
         2'd2:    rsp_chan.ready <= ($urandom_range(0, 5) == 0);
         default: rsp_chan.ready <= (stall_tick[3:0] > 4'd9);
      endcase
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (read_bytes_due.size() == 0) begin
            $error("unexpected response item, read_data %02h", rsp_chan.read_data);
            fail_count++;
         end else begin
            want = read_bytes_due.pop_front();
            if (rsp_chan.read_data !== want) begin
               $error("read_data mismatch: expected %02h, actual %02h",
                      want, rsp_chan.read_data);
               fail_count++;
            end
         end
      end
   end

endmodule

// ===== files.f =====
hdl/pfde_pkg.sv
hdl/pfde_if.sv
hdl/pfde_ram.sv
hdl/pfde_rmw.sv
hdl/pfde_ctrl.sv
hdl/page_framebuffer_draw_engine.sv
hdl/pfde_checker.sv
verif/tb_top.sv
